// ===== hw/rtl/tlbf_pkg.sv =====
`timescale 1ns / 1ps

package tlbf_pkg;

  localparam int KIND_W          = 2;
  localparam int UE_ID_W         = 8;
  localparam int RB_ID_W         = 5;
  localparam int WORD_W          = 32;
  localparam int WORD_IDX_W      = 5;
  localparam int DEF_NUM_USERS   = 256;
  localparam int DEF_NUM_BEARERS = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET   = 2'd0,
    KIND_CLR   = 2'd1,
    KIND_FIRST = 2'd2,
    KIND_NEXT  = 2'd3
  } kind_t;

  function automatic logic [WORD_IDX_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
    logic [WORD_IDX_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = WORD_IDX_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/tlbf_req_if.sv =====
`timescale 1ns / 1ps

interface tlbf_req_if;
  logic                             valid;
  logic                             ready;
  tlbf_pkg::kind_t                  kind;
  logic [tlbf_pkg::UE_ID_W-1:0]     ue_id;
  logic [tlbf_pkg::RB_ID_W-1:0]     rb_id;

  modport source (output valid, kind, ue_id, rb_id, input ready);
  modport sink   (input valid, kind, ue_id, rb_id, output ready);
endinterface

// ===== hw/rtl/tlbf_rsp_if.sv =====
`timescale 1ns / 1ps

interface tlbf_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [tlbf_pkg::UE_ID_W-1:0]     found_ue;
  logic [tlbf_pkg::RB_ID_W-1:0]     found_rb;

  modport source (output valid, found, found_ue, found_rb, input ready);
  modport sink   (input valid, found, found_ue, found_rb, output ready);
endinterface

// ===== hw/rtl/two_level_active_bitmap_finder_top.sv =====
`timescale 1ns / 1ps

// Two-level active bitmap finder. Each user owns a NUM_BEARERS-bit active-bearer mask in one
// synchronous memory, and a second memory holds one summary bit per user, 32 users to a word.
// Set and clear requests return found = 0 after a read-modify-write of both memories (states
// S_RD, S_UPD). Find-next first checks the given user's own mask above the given bearer (S_RD,
// S_NCHK). A user search (find-first, or find-next that falls through to later users) walks the
// summary words through the single read port, reading and checking each word in S_SUM_RD and
// S_SUM_CHK, then reads the chosen user's mask in S_BR_RD and S_BR_CHK. No more than
// ceil(NUM_USERS / 32) summary words are visited. One request is in flight at a time; a new
// request is taken while the previous result still waits at the output. Both stores read as zero
// right after reset through per-entry valid flags, so no clearing pass is needed.
module two_level_active_bitmap_finder_top #(
  parameter int NUM_USERS   = tlbf_pkg::DEF_NUM_USERS,
  parameter int NUM_BEARERS = tlbf_pkg::DEF_NUM_BEARERS
) (
  input  logic              clk,
  input  logic              rst_n,
  tlbf_req_if.sink          in_ch,
  tlbf_rsp_if.source        out_ch
);
  import tlbf_pkg::*;

  localparam int UE_W    = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int SUMW    = (NUM_USERS + WORD_W - 1) / WORD_W;
  localparam int SW_W    = (SUMW > 1) ? $clog2(SUMW) : 1;
  localparam int NB      = NUM_BEARERS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_UPD,
    S_NCHK,
    S_SUM_RD,
    S_SUM_CHK,
    S_BR_RD,
    S_BR_CHK,
    S_OUT
  } state_t;

  state_t                 state_r;
  kind_t                  kind_r;
  logic [UE_ID_W-1:0]     ue_r;
  logic [RB_ID_W-1:0]     rb_r;
  logic [UE_ID_W-1:0]     start_r;
  logic [SW_W-1:0]        blk_r;
  logic                   first_blk_r;
  logic [UE_W-1:0]        u_r;
  logic                   res_found_r;
  logic [UE_ID_W-1:0]     res_ue_r;
  logic [RB_ID_W-1:0]     res_rb_r;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [UE_ID_W-1:0]     out_ue_r;
  logic [RB_ID_W-1:0]     out_rb_r;

  logic [NB-1:0]          mask_mem [NUM_USERS];
  logic [NUM_USERS-1:0]   mask_vld_r;
  logic [NB-1:0]          mask_rdata_r;
  logic                   mask_rvld_r;
  logic [UE_W-1:0]        mask_raddr;
  logic                   mask_we;
  logic [NB-1:0]          mask_wdata;

  logic [WORD_W-1:0]      sum_mem [SUMW];
  logic [SUMW-1:0]        sum_vld_r;
  logic [WORD_W-1:0]      sum_rdata_r;
  logic                   sum_rvld_r;
  logic [SW_W-1:0]        sum_raddr;
  logic                   sum_we;
  logic [WORD_W-1:0]      sum_wdata;

  logic                   ue_ok;
  logic                   rb_ok;
  logic [UE_W-1:0]        ue_idx;
  logic [SW_W-1:0]        ue_blk;
  logic [NB-1:0]          mask_eff;
  logic [WORD_W-1:0]      sum_eff;
  logic [NB-1:0]          rb_bit;
  logic [WORD_W-1:0]      ue_bit;
  logic [NB-1:0]          above_rb;
  logic [NB-1:0]          mask_above;
  logic [WORD_W-1:0]      start_keep;
  logic [WORD_W-1:0]      sum_w;
  logic [UE_ID_W:0]       cand_u;
  logic [UE_ID_W:0]       next_start;
  logic                   in_fire;
  logic                   out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign ue_ok  = {1'b0, ue_r} < (UE_ID_W + 1)'(NUM_USERS);
  assign rb_ok  = {1'b0, rb_r} < (RB_ID_W + 1)'(NB);
  assign ue_idx = UE_W'(ue_r);
  assign ue_blk = SW_W'(ue_r >> WORD_IDX_W);

  assign mask_eff = mask_rvld_r ? mask_rdata_r : '0;
  assign sum_eff  = sum_rvld_r ? sum_rdata_r : '0;
  assign rb_bit   = NB'(1) << rb_r;
  assign ue_bit   = WORD_W'(1) << ue_r[WORD_IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      above_rb[i] = RB_ID_W'(i) > rb_r;
    end
    for (int i = 0; i < WORD_W; i++) begin
      start_keep[i] = !first_blk_r || (WORD_IDX_W'(i) >= start_r[WORD_IDX_W-1:0]);
    end
  end

  assign mask_above = mask_eff & above_rb;
  assign sum_w      = sum_eff & start_keep;
  assign cand_u     = ((UE_ID_W + 1)'(blk_r) << WORD_IDX_W)
                    | (UE_ID_W + 1)'(lowest_bit(sum_w));
  assign next_start = {1'b0, ue_r} + (UE_ID_W + 1)'(1);

  always_comb begin
    mask_raddr = (state_r == S_BR_RD) ? u_r : ue_idx;
    sum_raddr  = (state_r == S_SUM_RD) ? blk_r : ue_blk;
    mask_we    = (state_r == S_UPD) && ue_ok && rb_ok;
    sum_we     = mask_we;
    if (kind_r == KIND_SET) begin
      mask_wdata = mask_eff | rb_bit;
      sum_wdata  = sum_eff | ue_bit;
    end else begin
      mask_wdata = mask_eff & ~rb_bit;
      sum_wdata  = (mask_wdata == '0) ? (sum_eff & ~ue_bit) : sum_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[ue_idx] <= mask_wdata;
    end
    mask_rdata_r <= mask_mem[mask_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[ue_blk] <= sum_wdata;
    end
    sum_rdata_r <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_vld_r  <= '0;
      sum_vld_r   <= '0;
      mask_rvld_r <= 1'b0;
      sum_rvld_r  <= 1'b0;
    end else begin
      if (mask_we) begin
        mask_vld_r[ue_idx] <= 1'b1;
      end
      if (sum_we) begin
        sum_vld_r[ue_blk] <= 1'b1;
      end
      mask_rvld_r <= mask_vld_r[mask_raddr];
      sum_rvld_r  <= sum_vld_r[sum_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r      <= in_ch.kind;
            ue_r        <= in_ch.ue_id;
            rb_r        <= in_ch.rb_id;
            res_found_r <= 1'b0;
            res_ue_r    <= '0;
            res_rb_r    <= '0;
            start_r     <= '0;
            blk_r       <= '0;
            first_blk_r <= 1'b1;
            state_r     <= (in_ch.kind == KIND_FIRST) ? S_SUM_RD : S_RD;
          end
        end
        S_RD: begin
          state_r <= (kind_r == KIND_NEXT) ? S_NCHK : S_UPD;
        end
        S_UPD: begin
          state_r <= S_OUT;
        end
        S_NCHK: begin
          if ((rb_r != RB_ID_W'(NB - 1)) && ue_ok && rb_ok && (mask_above != '0)) begin
            res_found_r <= 1'b1;
            res_ue_r    <= ue_r;
            res_rb_r    <= lowest_bit(WORD_W'(mask_above));
            state_r     <= S_OUT;
          end else if (ue_ok && (ue_r != UE_ID_W'(NUM_USERS - 1))) begin
            start_r     <= UE_ID_W'(next_start);
            blk_r       <= SW_W'(next_start >> WORD_IDX_W);
            first_blk_r <= 1'b1;
            state_r     <= S_SUM_RD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_SUM_RD: begin
          state_r <= S_SUM_CHK;
        end
        S_SUM_CHK: begin
          if (sum_w != '0) begin
            if (cand_u >= (UE_ID_W + 1)'(NUM_USERS)) begin
              state_r <= S_OUT;
            end else begin
              u_r     <= UE_W'(cand_u);
              state_r <= S_BR_RD;
            end
          end else if (blk_r == SW_W'(SUMW - 1)) begin
            state_r <= S_OUT;
          end else begin
            blk_r       <= blk_r + SW_W'(1);
            first_blk_r <= 1'b0;
            state_r     <= S_SUM_RD;
          end
        end
        S_BR_RD: begin
          state_r <= S_BR_CHK;
        end
        S_BR_CHK: begin
          if (mask_eff != '0) begin
            res_found_r <= 1'b1;
            res_ue_r    <= UE_ID_W'(u_r);
            res_rb_r    <= lowest_bit(WORD_W'(mask_eff));
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_ue_r    <= res_ue_r;
            out_rb_r    <= res_rb_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.found_ue = out_ue_r;
  assign out_ch.found_rb = out_rb_r;

endmodule

// ===== dv/tb_two_level_active_bitmap_finder_top.sv =====
`timescale 1ns / 1ps

module tb_two_level_active_bitmap_finder_top;
  import tlbf_pkg::*;

  localparam int NUSERS    = DEF_NUM_USERS;
  localparam int NBEARERS  = DEF_NUM_BEARERS;
  localparam int SUM_WORDS = (NUSERS + WORD_W - 1) / WORD_W;
  localparam int RAND_ITEMS = 1650;

  typedef struct packed {
    kind_t              kind;
    logic [UE_ID_W-1:0] ue;
    logic [RB_ID_W-1:0] rb;
  } lookup_req_t;

  typedef struct packed {
    logic               found;
    logic [UE_ID_W-1:0] ue;
    logic [RB_ID_W-1:0] rb;
  } lookup_rsp_t;

  typedef struct {
    lookup_req_t req;
    int unsigned gap;
    bit          wait_drain;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlbf_req_if in_ch ();
  tlbf_rsp_if out_ch ();

  two_level_active_bitmap_finder_top #(
    .NUM_USERS  (NUSERS),
    .NUM_BEARERS(NBEARERS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted block state
  logic [WORD_W-1:0] summary_words [SUM_WORDS];
  logic [WORD_W-1:0] bearer_mask   [NUSERS];

  // Stimulus bookkeeping
  logic [WORD_W-1:0]          gen_mask [NUSERS];
  logic [UE_ID_W+RB_ID_W-1:0] gen_pairs[$];
  request_t                   requests_todo[$];
  lookup_rsp_t                answers_due[$];
  int unsigned                n_queued;
  bit                         quiet;

  request_t    stg;
  bit          staged;
  int unsigned hold_cnt;
  int unsigned n_accepted;
  int unsigned n_returned;
  int unsigned kind_cnt [4];

  int unsigned n_checked;
  int unsigned n_hits;
  int unsigned rx_stall;
  int unsigned rx_long_hold;
  int unsigned err_cnt;

  function automatic int unsigned lsb_index(input logic [WORD_W-1:0] w);
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) begin
        return i;
      end
    end
    return 0;
  endfunction

  function automatic lookup_rsp_t scan_users(input int unsigned start);
    lookup_rsp_t       r;
    logic [WORD_W-1:0] w;
    int unsigned       base;
    int unsigned       u;
    r = '0;
    for (int blk = start / WORD_W; blk < SUM_WORDS; blk++) begin
      base = blk * WORD_W;
      w = summary_words[blk];
      if (start > base) begin
        w = w & ~((32'h1 << (start - base)) - 32'h1);
      end
      if (w != '0) begin
        u = base + lsb_index(w);
        if (u < NUSERS && bearer_mask[u] != '0) begin
          r.found = 1'b1;
          r.ue    = UE_ID_W'(u);
          r.rb    = RB_ID_W'(lsb_index(bearer_mask[u]));
        end
        return r;
      end
    end
    return r;
  endfunction

  function automatic lookup_rsp_t bitmap_apply(input lookup_req_t q);
    lookup_rsp_t       r;
    logic [WORD_W-1:0] rest;
    r = '0;
    rest = '0;
    case (q.kind)
      KIND_SET: begin
        summary_words[q.ue / WORD_W][q.ue % WORD_W] = 1'b1;
        bearer_mask[q.ue][q.rb] = 1'b1;
      end
      KIND_CLR: begin
        bearer_mask[q.ue][q.rb] = 1'b0;
        if (bearer_mask[q.ue] == '0) begin
          summary_words[q.ue / WORD_W][q.ue % WORD_W] = 1'b0;
        end
      end
      KIND_FIRST: begin
        r = scan_users(0);
      end
      KIND_NEXT: begin
        if (q.rb != NBEARERS - 1) begin
          rest = bearer_mask[q.ue] & ~((32'h2 << q.rb) - 32'h1);
        end
        if (rest != '0) begin
          r.found = 1'b1;
          r.ue    = q.ue;
          r.rb    = RB_ID_W'(lsb_index(rest));
        end else if (q.ue != NUSERS - 1) begin
          r = scan_users(q.ue + 1);
        end
      end
    endcase
    return r;
  endfunction

  task automatic queue_req(input kind_t k, input logic [UE_ID_W-1:0] ue,
                           input logic [RB_ID_W-1:0] rb);
    request_t item;
    int       idx;
    item.req        = '{k, ue, rb};
    item.gap        = (quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    item.wait_drain = (n_queued == 7 || n_queued == 800 || n_queued == 1400);
    idx = -1;
    if (k == KIND_SET && !gen_mask[ue][rb]) begin
      gen_mask[ue][rb] = 1'b1;
      gen_pairs.push_back({ue, rb});
    end else if (k == KIND_CLR && gen_mask[ue][rb]) begin
      gen_mask[ue][rb] = 1'b0;
      for (int j = 0; j < gen_pairs.size(); j++) begin
        if (gen_pairs[j] == {ue, rb}) begin
          idx = j;
        end
      end
      if (idx >= 0) begin
        gen_pairs.delete(idx);
      end
    end
    requests_todo.push_back(item);
    n_queued++;
  endtask

  // Driver: offer queued transactions, hold while stalled
  always @(posedge clk) begin : drive
    logic nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      staged   = 1'b0;
      hold_cnt = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        answers_due.push_back(bitmap_apply('{in_ch.kind, in_ch.ue_id, in_ch.rb_id}));
        kind_cnt[in_ch.kind]++;
        n_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_returned++;
      end
      nv = in_ch.valid && !in_ch.ready;
      if (!nv) begin
        if (!staged && requests_todo.size() > 0) begin
          stg      = requests_todo.pop_front();
          hold_cnt = stg.gap;
          staged   = 1'b1;
        end
        if (staged) begin
          if (hold_cnt > 0) begin
            hold_cnt--;
          end else if (!(stg.wait_drain && n_accepted != n_returned)) begin
            nv = 1'b1;
            staged = 1'b0;
            in_ch.kind  <= stg.req.kind;
            in_ch.ue_id <= stg.req.ue;
            in_ch.rb_id <= stg.req.rb;
          end
        end
      end
      in_ch.valid <= nv;
    end
  end

  // Monitor: accept results, compare against the oldest prediction
  always @(posedge clk) begin : watch
    lookup_rsp_t got;
    lookup_rsp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall     = 0;
      rx_long_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.found, out_ch.found_ue, out_ch.found_rb};
        if (answers_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result found=%0d ue=%0d rb=%0d", $time,
                   got.found, got.ue, got.rb);
        end else begin
          want = answers_due.pop_front();
          if (got.found !== want.found) begin
            err_cnt++;
            $display("%0t: found mismatch: expected %0d, actual %0d", $time,
                     want.found, got.found);
          end
          if (got.ue !== want.ue) begin
            err_cnt++;
            $display("%0t: found_ue mismatch: expected %0d, actual %0d", $time,
                     want.ue, got.ue);
          end
          if (got.rb !== want.rb) begin
            err_cnt++;
            $display("%0t: found_rb mismatch: expected %0d, actual %0d", $time,
                     want.rb, got.rb);
          end
        end
        if (got.found === 1'b1) begin
          n_hits++;
        end
        n_checked++;
        rx_stall = ((n_checked / 150) % 4 == 3) ? 0 : $urandom_range(0, 17);
        if (n_checked == 400 || n_checked == 1300) begin
          rx_long_hold = 300;
        end
      end
      out_ch.ready <= (rx_long_hold == 0 && rx_stall == 0);
      if (rx_long_hold > 0) begin
        rx_long_hold--;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
    end
  end

  initial begin
    logic [UE_ID_W+RB_ID_W-1:0] p;
    logic [UE_ID_W-1:0]         hot_base;
    logic [UE_ID_W-1:0]         u;
    int unsigned                sel;
    int unsigned                last_wipe;
    int unsigned                set_pct;

    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_SET;
    in_ch.ue_id  = '0;
    in_ch.rb_id  = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < SUM_WORDS; i++) begin
      summary_words[i] = '0;
    end
    for (int i = 0; i < NUSERS; i++) begin
      bearer_mask[i] = '0;
      gen_mask[i]    = '0;
    end

    // empty bitmap, then boundary users and bearers
    queue_req(KIND_FIRST, 8'd0, 5'd0);
    queue_req(KIND_NEXT, 8'd0, 5'd0);
    queue_req(KIND_SET, 8'd0, 5'd0);
    queue_req(KIND_SET, 8'd255, 5'd31);
    queue_req(KIND_SET, 8'd31, 5'd31);
    queue_req(KIND_SET, 8'd32, 5'd0);
    queue_req(KIND_SET, 8'd0, 5'd31);
    queue_req(KIND_FIRST, 8'd255, 5'd31);
    queue_req(KIND_NEXT, 8'd0, 5'd0);
    queue_req(KIND_NEXT, 8'd0, 5'd31);
    queue_req(KIND_NEXT, 8'd31, 5'd31);
    queue_req(KIND_NEXT, 8'd32, 5'd0);
    queue_req(KIND_NEXT, 8'd255, 5'd31);
    queue_req(KIND_NEXT, 8'd255, 5'd0);
    queue_req(KIND_NEXT, 8'd100, 5'd5);
    queue_req(KIND_SET, 8'd170, 5'd21);
    queue_req(KIND_SET, 8'd85, 5'd10);
    queue_req(KIND_CLR, 8'd0, 5'd0);
    queue_req(KIND_CLR, 8'd0, 5'd31);
    queue_req(KIND_FIRST, 8'd0, 5'd0);
    queue_req(KIND_CLR, 8'd7, 5'd7);
    queue_req(KIND_CLR, 8'd31, 5'd31);
    queue_req(KIND_CLR, 8'd32, 5'd0);
    queue_req(KIND_CLR, 8'd255, 5'd31);
    queue_req(KIND_CLR, 8'd170, 5'd21);
    queue_req(KIND_CLR, 8'd85, 5'd10);
    queue_req(KIND_FIRST, 8'd0, 5'd0);

    hot_base  = UE_ID_W'($urandom_range(0, 255));
    last_wipe = n_queued;
    while (n_queued < RAND_ITEMS + 27) begin
      quiet = ((n_queued / 120) % 5 == 2);
      if (n_queued - last_wipe >= 300) begin
        while (gen_pairs.size() > 0) begin
          p = gen_pairs[$urandom_range(0, gen_pairs.size() - 1)];
          queue_req(KIND_CLR, p[RB_ID_W +: UE_ID_W], p[RB_ID_W-1:0]);
        end
        queue_req(KIND_FIRST, UE_ID_W'($urandom), RB_ID_W'($urandom));
        queue_req(KIND_NEXT, UE_ID_W'($urandom), RB_ID_W'($urandom));
        hot_base  = UE_ID_W'($urandom_range(0, 255));
        last_wipe = n_queued;
      end
      sel     = $urandom_range(0, 99);
      set_pct = (gen_pairs.size() > 40) ? 15 : 35;
      u = ($urandom_range(0, 3) == 0) ? UE_ID_W'($urandom_range(0, 255))
                                      : hot_base + UE_ID_W'($urandom_range(0, 47));
      if (sel < set_pct) begin
        queue_req(KIND_SET, u, RB_ID_W'($urandom_range(0, 31)));
      end else if (sel < 55) begin
        if (gen_pairs.size() > 0 && $urandom_range(0, 4) != 0) begin
          p = gen_pairs[$urandom_range(0, gen_pairs.size() - 1)];
          queue_req(KIND_CLR, p[RB_ID_W +: UE_ID_W], p[RB_ID_W-1:0]);
        end else begin
          queue_req(KIND_CLR, u, RB_ID_W'($urandom_range(0, 31)));
        end
      end else if (sel < 65) begin
        queue_req(KIND_FIRST, UE_ID_W'($urandom), RB_ID_W'($urandom));
      end else if (sel < 75 && gen_pairs.size() > 0) begin
        // walk one user's active bearers in order
        p = gen_pairs[$urandom_range(0, gen_pairs.size() - 1)];
        u = p[RB_ID_W +: UE_ID_W];
        for (int b = 0; b < NBEARERS; b++) begin
          if (gen_mask[u][b]) begin
            queue_req(KIND_NEXT, u, RB_ID_W'(b));
          end
        end
      end else if (gen_pairs.size() > 0 && $urandom_range(0, 4) < 3) begin
        p = gen_pairs[$urandom_range(0, gen_pairs.size() - 1)];
        queue_req(KIND_NEXT, p[RB_ID_W +: UE_ID_W], p[RB_ID_W-1:0]);
      end else begin
        queue_req(KIND_NEXT, u, RB_ID_W'($urandom_range(0, 31)));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_todo.size() != 0 || staged || in_ch.valid || answers_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    if (answers_due.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, answers_due.size());
    end
    $display("Covered %0d requests: %0d set, %0d clear, %0d find-first, %0d find-next",
             n_accepted, kind_cnt[KIND_SET], kind_cnt[KIND_CLR], kind_cnt[KIND_FIRST],
             kind_cnt[KIND_NEXT]);
    $display("Checked %0d results, %0d searches located a bearer", n_checked, n_hits);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, answers_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
